[src/mctg_pkg.sv]
package mctg_pkg;

  localparam int DAY_MINUTES_DEF = 1440;
  localparam int MIN_PER_HOUR    = 60;
  localparam int GAP_MAX         = 1023;

  localparam int HOURS_W  = 5;
  localparam int MINUTE_W = 6;
  localparam int GAP_W    = 10;
  // hours * 60 + minute for any 5-bit/6-bit word fits here
  localparam int RAW_W    = 11;

endpackage

[src/min_circular_time_gap_top.sv]
// A non-last word is taken, then stalls the input through one shared-subtractor step
//   modulo DAY_MINUTES, a map read and a map mark.
// A last word adds a scan of every map entry plus drain, wrap and result states; min_gap
//   is registered from the result state, which waits while an older min_gap is stalled.
// Words are taken one at a time, and a set's scan also stalls the input: the single map port sets the pace.
// Reset: control clears at once, then a pass over all map entries zeroes the map, input stalled.
module min_circular_time_gap_top #(
  parameter int DAY_MINUTES = mctg_pkg::DAY_MINUTES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [mctg_pkg::HOURS_W-1:0]  hours_i,
  input  logic [mctg_pkg::MINUTE_W-1:0] minute_i,
  input  logic                         last_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic [mctg_pkg::GAP_W-1:0]    min_gap_o
);

  import mctg_pkg::*;

  localparam int AW = (DAY_MINUTES > 1) ? $clog2(DAY_MINUTES) : 1;
  localparam int GW = AW + 1;
  localparam int W  = (GW > RAW_W) ? GW : RAW_W;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_REDUCE, ST_LOOKUP, ST_MARK,
    ST_SCAN, ST_DRAIN, ST_WRAP, ST_RESULT
  } state_e;

  state_e            state_q;
  logic [RAW_W-1:0]  raw_q;
  logic              last_q;
  logic [AW-1:0]     idx_q;
  logic [AW-1:0]     pidx_q;
  logic              pend_q;
  logic              any_q;
  logic              dup_q;
  logic [AW-1:0]     first_q;
  logic [AW-1:0]     prev_q;
  logic [GW-1:0]     best_q;
  logic              out_valid_q;
  logic [GAP_W-1:0]  min_gap_q;

  logic [W-1:0]  alu_a, alu_b, alu_lim, alu_diff;
  logic          alu_ge, alu_lt;
  logic [AW-1:0] map_addr;
  logic          map_we, map_wdata, map_rdata;
  logic          hit;
  logic [GAP_W-1:0] gap_res;

  // each entry below DAY_MINUTES, so the sum needs one conditional subtract
  logic [RAW_W-1:0] hour_tab [2**HOURS_W];
  logic [RAW_W-1:0] min_tab  [2**MINUTE_W];

  for (genvar g = 0; g < 2**HOURS_W; g++) begin : g_hour_tab
    assign hour_tab[g] = RAW_W'((g * MIN_PER_HOUR) % DAY_MINUTES);
  end

  for (genvar g = 0; g < 2**MINUTE_W; g++) begin : g_min_tab
    assign min_tab[g] = RAW_W'(g % DAY_MINUTES);
  end

  mctg_alu #(.W(W)) u_alu (
    .a_i   (alu_a),
    .b_i   (alu_b),
    .lim_i (alu_lim),
    .diff_o(alu_diff),
    .ge_o  (alu_ge),
    .lt_o  (alu_lt)
  );

  mctg_map #(.DEPTH(DAY_MINUTES), .AW(AW)) u_map (
    .clk_i  (clk_i),
    .addr_i (map_addr),
    .we_i   (map_we),
    .wdata_i(map_wdata),
    .rdata_o(map_rdata)
  );

  assign hit = pend_q && map_rdata;

  always_comb begin
    alu_a   = W'(pidx_q);
    alu_b   = W'(prev_q);
    alu_lim = W'(best_q);
    case (state_q)
      ST_REDUCE: begin
        alu_a   = W'(raw_q);
        alu_b   = W'(DAY_MINUTES);
        alu_lim = '0;
      end
      ST_WRAP: begin
        alu_a = W'(first_q) + W'(DAY_MINUTES);
      end
      default: ;
    endcase
  end

  always_comb begin
    map_addr  = idx_q;
    map_we    = 1'b0;
    map_wdata = 1'b0;
    case (state_q)
      ST_CLEAR, ST_SCAN: begin
        map_we = 1'b1;
      end
      ST_LOOKUP: begin
        map_addr = AW'(raw_q);
      end
      ST_MARK: begin
        map_addr  = AW'(raw_q);
        map_we    = 1'b1;
        map_wdata = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    if (dup_q || !any_q || prev_q == first_q) begin
      gap_res = '0;
    end else if (32'(best_q) > 32'(GAP_MAX)) begin
      gap_res = GAP_W'(GAP_MAX);
    end else begin
      gap_res = GAP_W'(best_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      raw_q       <= '0;
      last_q      <= 1'b0;
      idx_q       <= '0;
      pidx_q      <= '0;
      pend_q      <= 1'b0;
      any_q       <= 1'b0;
      dup_q       <= 1'b0;
      first_q     <= '0;
      prev_q      <= '0;
      best_q      <= '1;
      out_valid_q <= 1'b0;
      min_gap_q   <= '0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_RESULT) begin
        out_valid_q <= 1'b0;
      end
      if ((state_q == ST_SCAN || state_q == ST_DRAIN) && hit) begin
        if (!any_q) begin
          first_q <= pidx_q;
          any_q   <= 1'b1;
        end else if (alu_lt) begin
          best_q <= alu_diff[GW-1:0];
        end
        prev_q <= pidx_q;
      end
      case (state_q)
        ST_CLEAR: begin
          if (idx_q == AW'(DAY_MINUTES - 1)) begin
            idx_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid_i) begin
            raw_q   <= hour_tab[hours_i] + min_tab[minute_i];
            last_q  <= last_i;
            state_q <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          if (alu_ge) begin
            raw_q <= alu_diff[RAW_W-1:0];
          end
          state_q <= ST_LOOKUP;
        end
        ST_LOOKUP: begin
          state_q <= ST_MARK;
        end
        ST_MARK: begin
          if (map_rdata) begin
            dup_q <= 1'b1;
          end
          if (last_q) begin
            idx_q   <= '0;
            pend_q  <= 1'b0;
            any_q   <= 1'b0;
            best_q  <= '1;
            state_q <= ST_SCAN;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          pend_q <= 1'b1;
          pidx_q <= idx_q;
          if (idx_q == AW'(DAY_MINUTES - 1)) begin
            idx_q   <= '0;
            state_q <= ST_DRAIN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          pend_q  <= 1'b0;
          state_q <= ST_WRAP;
        end
        ST_WRAP: begin
          if (any_q && alu_lt) begin
            best_q <= alu_diff[GW-1:0];
          end
          state_q <= ST_RESULT;
        end
        ST_RESULT: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            min_gap_q   <= gap_res;
            dup_q       <= 1'b0;
            any_q       <= 1'b0;
            first_q     <= '0;
            prev_q      <= '0;
            best_q      <= '1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign min_gap_o   = min_gap_q;

  a_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_LOOKUP |-> 32'(raw_q) < DAY_MINUTES)
    else $error("minute of day not reduced below DAY_MINUTES");

  a_reduce_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_REDUCE |=> state_q == ST_LOOKUP)
    else $error("reduction did not end after one step");

  a_gap_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> 32'(min_gap_o) <= DAY_MINUTES / 2)
    else $error("gap exceeds half a day");

  a_rise_from_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_RESULT))
    else $error("result word not from result state");

endmodule

[src/mctg_alu.sv]
module mctg_alu #(
  parameter int W = 16
) (
  input  logic [W-1:0] a_i,
  input  logic [W-1:0] b_i,
  input  logic [W-1:0] lim_i,
  output logic [W-1:0] diff_o,
  output logic         ge_o,
  output logic         lt_o
);

  logic [W:0] ext;

  assign ext    = {1'b0, a_i} - {1'b0, b_i};
  assign diff_o = ext[W-1:0];
  assign ge_o   = ~ext[W];
  assign lt_o   = ext[W-1:0] < lim_i;

endmodule

[src/mctg_map.sv]
module mctg_map #(
  parameter int DEPTH = 1440,
  parameter int AW    = 11
) (
  input  logic          clk_i,
  input  logic [AW-1:0] addr_i,
  input  logic          we_i,
  input  logic          wdata_i,
  output logic          rdata_o
);

  logic mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule
